### hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted double-ended job queue.
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ID_W  = 16;
    localparam int PRI_W = 16;

    typedef enum logic [1:0] {
        CMD_INSERT    = 2'd0,
        CMD_REM_FRONT = 2'd1,
        CMD_REM_REAR  = 2'd2,
        CMD_FIND      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [PRI_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic ge;
        logic eq;
    } cmp_res_t;

    typedef struct packed {
        status_t status;
        entry_t  job;
    } result_t;

endpackage

### hw/rtl/sorted_priority_queue_double_ended.sv
// Sorted double-ended job queue: holds up to 16 jobs (id, signed priority) in ascending
// priority order; a command takes one input beat and returns one result beat. Insert
// places the job ahead of equal priorities, remove-front pops the lowest priority,
// remove-rear pops the highest, find returns the first matching id from the front.
// Every command runs through a sequencer that walks the slot memory one entry at a time:
// a registered read, then the shared compare and any write. Refused or empty-store commands
// go straight to the result; remove-rear reads only the last entry; insert moves entries up
// from the rear until it meets a lower entry or reaches the front; remove-front walks every
// held entry, moving each down a slot; find walks from the front to a match or the last
// entry. The single memory port pair sets the pace of this walk. The input is stalled while
// a command is in progress; the result sits in an output register, so the next command is
// accepted while an earlier result still waits to be taken.
module sorted_priority_queue_double_ended (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [15:0]        job_id,
    input  logic signed [15:0] job_priority,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [15:0]        out_id,
    output logic signed [15:0] out_priority
);
    import spq_pkg::*;

    mem_req_t mem_req;
    entry_t   rdata;
    entry_t   key;
    cmp_res_t cmp;
    logic     busy;
    logic     done_valid;
    result_t  done;
    logic     out_free;
    logic     out_valid_reg;
    result_t  out_reg;

    // Slot memory: ids and priorities side by side.
    spq_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    // One comparator serves both the sorted walk and the id search.
    spq_cmp u_cmp (
        .entry (rdata),
        .key   (key),
        .res   (cmp)
    );

    spq_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .cmd          (cmd),
        .job_id       (job_id),
        .job_priority (job_priority),
        .busy         (busy),
        .mem_req      (mem_req),
        .rdata        (rdata),
        .key          (key),
        .cmp          (cmp),
        .done_valid   (done_valid),
        .done         (done),
        .out_free     (out_free)
    );

    // Hold the input off while the sequencer is working.
    assign in_stall = busy;

    // The output register can take a new result when empty or being drained this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_valid && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result beat; hold it while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (done_valid && out_free)
        begin
            out_reg <= done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign out_id       = out_reg.job.id;
    assign out_priority = out_reg.job.prio;

endmodule

### hw/rtl/spq_mem.sv
// Job slot memory: one write port, one read port with registered read data.
module spq_mem (
    input  logic              clk,
    input  spq_pkg::mem_req_t req,
    output spq_pkg::entry_t   rdata
);
    import spq_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

### hw/rtl/spq_cmp.sv
// Shared compare unit: signed priority order and id match against the key.
module spq_cmp (
    input  spq_pkg::entry_t   entry,
    input  spq_pkg::entry_t   key,
    output spq_pkg::cmp_res_t res
);
    import spq_pkg::*;

    always_comb
    begin
        res.ge = (entry.prio >= key.prio);
        res.eq = (entry.id == key.id);
    end

endmodule

### hw/rtl/spq_seq.sv
// Command sequencer: walks the slot memory one entry at a time.
module spq_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        cmd,
    input  logic [15:0]       job_id,
    input  logic signed [15:0] job_priority,
    output logic              busy,
    output spq_pkg::mem_req_t mem_req,
    input  spq_pkg::entry_t   rdata,
    output spq_pkg::entry_t   key,
    input  spq_pkg::cmp_res_t cmp,
    output logic              done_valid,
    output spq_pkg::result_t  done,
    input  logic              out_free
);
    import spq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_CHECK = 5'b00100,
        S_PLACE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    cmd_t               cmd_reg, cmd_next;
    entry_t             key_reg, key_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    result_t            res_reg, res_next;
    logic [CNT_W-1:0]   idx_prev;
    logic [CNT_W-1:0]   last_idx;
    logic               accept;

    assign busy       = (state_reg != S_IDLE);
    assign accept     = in_valid && !busy;
    assign key        = key_reg;
    assign done_valid = (state_reg == S_DONE);
    assign done       = res_reg;
    assign idx_prev   = idx_reg - CNT_W'(1);
    assign last_idx   = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        idx_next      = idx_reg;
        res_next      = res_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg[IDX_W-1:0];
        mem_req.wdata = rdata;
        // Insert walks from the rear, so it reads the slot below the hole.
        mem_req.raddr = (cmd_reg == CMD_INSERT) ? idx_prev[IDX_W-1:0]
                                                : idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next      = cmd_t'(cmd);
                    key_next.id   = job_id;
                    key_next.prio = job_priority;
                    res_next      = '0;
                    case (cmd_t'(cmd)) inside
                        CMD_INSERT:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_next.status = ST_FULL;
                                state_next      = S_DONE;
                            end
                            else if (count_reg == '0)
                            begin
                                idx_next   = '0;
                                state_next = S_PLACE;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_READ;
                            end
                        end
                        CMD_REM_FRONT, CMD_REM_REAR:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                idx_next   = (cmd_t'(cmd) == CMD_REM_REAR) ? last_idx : '0;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_NOTFOUND;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_READ;
                            end
                        end
                    endcase
                end
            end

            S_READ:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        mem_req.we = 1'b1;
                        if (cmp.ge)
                        begin
                            // Shift the entry up one slot and keep walking down.
                            idx_next   = idx_prev;
                            state_next = (idx_reg == CNT_W'(1)) ? S_PLACE : S_READ;
                        end
                        else
                        begin
                            mem_req.wdata = key_reg;
                            count_next    = count_reg + CNT_W'(1);
                            state_next    = S_DONE;
                        end
                    end
                    CMD_REM_FRONT:
                    begin
                        if (idx_reg == '0)
                        begin
                            res_next.status = ST_OK;
                            res_next.job    = rdata;
                        end
                        else
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = idx_prev[IDX_W-1:0];
                        end
                        if (idx_reg == last_idx)
                        begin
                            count_next = last_idx;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + CNT_W'(1);
                            state_next = S_READ;
                        end
                    end
                    CMD_REM_REAR:
                    begin
                        res_next.status = ST_OK;
                        res_next.job    = rdata;
                        count_next      = last_idx;
                        state_next      = S_DONE;
                    end
                    default:
                    begin
                        if (cmp.eq)
                        begin
                            res_next.status = ST_OK;
                            res_next.job    = rdata;
                            state_next      = S_DONE;
                        end
                        else if (idx_reg == last_idx)
                        begin
                            res_next.status = ST_NOTFOUND;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + CNT_W'(1);
                            state_next = S_READ;
                        end
                    end
                endcase
            end

            S_PLACE:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = key_reg;
                count_next    = count_reg + CNT_W'(1);
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

endmodule

### hw/rtl/spq_checker.sv
// Port-level checker for the sorted double-ended job queue, with its bind.
module spq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [15:0] out_id,
    input logic [15:0] out_priority
);
    import spq_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_id)
            && $stable(out_priority))
        else $error("result beat changed while stalled");

    // Failed commands carry no job.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (out_id == '0) && (out_priority == '0))
        else $error("non-ok result carries job data");

    // An accepted command always occupies the block for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after command accept");

    // A fresh result appears only after the block was busy.
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a command in progress");

endmodule

bind sorted_priority_queue_double_ended spq_checker u_spq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_id       (out_id),
    .out_priority (out_priority)
);

### verif/testbench.sv
// Self-checking testbench for the sorted double-ended job queue.
`timescale 1ns / 100ps

module testbench;
    import spq_pkg::*;

    // Stop the run after this many cycles with no beat on either channel.
    localparam int STALL_LIMIT   = 3000;
    // Let the slowest commands (remove-front or a missing find on a full store) settle at the end.
    localparam int SETTLE_CYCLES = 40;
    localparam int RAND_ITEMS    = 425;
    localparam int IDLE_PCT      = 22;
    // Random item that waits for every outstanding result before it is offered.
    localparam int DRAIN_ITEM    = 300;
    // Result count at which the receiver holds off for a long stretch.
    localparam int HOLD_AT       = 100;
    localparam int HOLD_CYCLES   = 80;
    // Window of beats with no idling on either side.
    localparam int CALM_LO       = 200;
    localparam int CALM_HI       = 280;

    typedef struct {
        cmd_t               op;
        logic [ID_W-1:0]    id;
        logic signed [15:0] prio;
        bit                 drain_first;
    } job_cmd_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd = CMD_INSERT;
    logic [15:0]        job_id = '0;
    logic signed [15:0] job_priority = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic [15:0]        out_id;
    logic signed [15:0] out_priority;

    // Commands waiting to be driven, and results owed by the block, oldest first.
    job_cmd_t job_cmds[$];
    result_t  due_results[$];

    // Shadow of the job store, ascending priority from index 0.
    entry_t job_store[DEPTH];
    int     store_count = 0;

    int n_sent = 0;
    int n_done = 0;
    int err_cnt = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    sorted_priority_queue_double_ended dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .job_id       (job_id),
        .job_priority (job_priority),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_id       (out_id),
        .out_priority (out_priority)
    );

    // Apply one command to the shadow store and return the result it owes.
    function automatic result_t apply_job_cmd(job_cmd_t c);
        result_t r;
        int      pos;
        r.status = ST_OK;
        r.job    = '0;
        pos      = 0;
        case (c.op)
            CMD_INSERT:
            begin
                if (store_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // Land ahead of the first entry whose priority is not below ours.
                    while (pos < store_count && $signed(job_store[pos].prio) < $signed(c.prio))
                        pos++;
                    for (int i = store_count; i > pos; i--)
                        job_store[i] = job_store[i-1];
                    job_store[pos].id   = c.id;
                    job_store[pos].prio = c.prio;
                    store_count++;
                end
            end
            CMD_REM_FRONT:
            begin
                if (store_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.job = job_store[0];
                    for (int i = 1; i < store_count; i++)
                        job_store[i-1] = job_store[i];
                    store_count--;
                end
            end
            CMD_REM_REAR:
            begin
                if (store_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    store_count--;
                    r.job = job_store[store_count];
                end
            end
            default:
            begin
                // Search from the front; the first id match wins.
                r.status = ST_NOTFOUND;
                for (int i = 0; i < store_count; i++)
                begin
                    if (r.status == ST_NOTFOUND && job_store[i].id == c.id)
                    begin
                        r.status = ST_OK;
                        r.job    = job_store[i];
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic void add_cmd(cmd_t op, logic [15:0] id, logic signed [15:0] prio,
                                    bit drain_first);
        job_cmd_t c;
        c.op          = op;
        c.id          = id;
        c.prio        = prio;
        c.drain_first = drain_first;
        job_cmds.push_back(c);
    endfunction

    // Favor a narrow band so equal priorities are common; mix in extremes and full range.
    function automatic logic signed [15:0] rand_prio();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return 16'(int'($urandom_range(0, 8)) - 4);
        else if (sel < 6)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'sh8000;
                1:       return 16'sh7FFF;
                2:       return 16'sh8001;
                default: return 16'sh7FFE;
            endcase
        end
        else
            return 16'($urandom());
    endfunction

    // Draw ids mostly from a small pool so finds hit and ids repeat.
    function automatic logic [15:0] rand_id();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return 16'($urandom_range(0, 7));
        else if (sel == 6)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        else
            return 16'($urandom());
    endfunction

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Stimulus: a directed opening, then random traffic with shifting insert bias.
    initial
    begin
        int ins_pct;
        int pick;
        cmd_t op;

        // Empty store: both removes report empty, find misses.
        add_cmd(CMD_REM_FRONT, 16'h0001, 16'sh0000, 1'b0);
        add_cmd(CMD_REM_REAR,  16'h0002, 16'sh7FFF, 1'b0);
        add_cmd(CMD_FIND,      16'h0000, 16'sh8000, 1'b0);
        // Fill to capacity with extremes, equal priorities and a repeated id.
        add_cmd(CMD_INSERT, 16'h0000, 16'sh8000, 1'b0);
        add_cmd(CMD_INSERT, 16'hFFFF, 16'sh7FFF, 1'b0);
        add_cmd(CMD_INSERT, 16'h0001, 16'sh0000, 1'b0);
        add_cmd(CMD_INSERT, 16'h0002, 16'sh0000, 1'b0);
        add_cmd(CMD_INSERT, 16'h0003, -16'sd1, 1'b0);
        add_cmd(CMD_INSERT, 16'h0004, 16'sd1, 1'b0);
        add_cmd(CMD_INSERT, 16'h8000, 16'sh7FFF, 1'b0);
        add_cmd(CMD_INSERT, 16'h0005, 16'sh8000, 1'b0);
        add_cmd(CMD_INSERT, 16'h0006, 16'sd100, 1'b0);
        add_cmd(CMD_INSERT, 16'h0006, -16'sd100, 1'b0);
        add_cmd(CMD_INSERT, 16'h0007, 16'sh8001, 1'b0);
        add_cmd(CMD_INSERT, 16'h0008, 16'sh7FFE, 1'b0);
        add_cmd(CMD_INSERT, 16'h0009, 16'sd5, 1'b0);
        add_cmd(CMD_INSERT, 16'h000A, -16'sd5, 1'b0);
        add_cmd(CMD_INSERT, 16'h000B, 16'sd7, 1'b0);
        add_cmd(CMD_INSERT, 16'h000C, -16'sd7, 1'b0);
        // Full store refuses the insert.
        add_cmd(CMD_INSERT, 16'h000D, 16'sh0000, 1'b0);
        // Repeated id returns the frontmost copy; then a hit at the top id and a miss.
        add_cmd(CMD_FIND, 16'h0006, 16'sh0000, 1'b0);
        add_cmd(CMD_FIND, 16'hFFFF, 16'sh0000, 1'b0);
        add_cmd(CMD_FIND, 16'h000D, 16'sh0000, 1'b0);
        add_cmd(CMD_REM_REAR,  16'h0000, 16'sh0000, 1'b0);
        add_cmd(CMD_REM_FRONT, 16'h0000, 16'sh0000, 1'b0);

        ins_pct = 50;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            // Swing between filling, draining and balanced traffic so the store
            // keeps crossing full and empty.
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       ins_pct = 70;
                    1:       ins_pct = 20;
                    default: ins_pct = 45;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < ins_pct)
                op = CMD_INSERT;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       op = CMD_REM_FRONT;
                    1:       op = CMD_REM_REAR;
                    default: op = CMD_FIND;
                endcase
            end
            add_cmd(op, rand_id(), rand_prio(), n == DRAIN_ITEM);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every command is taken and every result has come back.
        while (job_cmds.size() != 0 || due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (err_cnt == 0 && due_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Driver: present the head of job_cmds, hold it while stalled, advance on a beat.
    always @(posedge clk or negedge rst_n)
    begin
        bit took;
        bit calm;
        bit drain_wait;
        int sent_now;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            took     = in_valid && !in_stall;
            sent_now = n_sent + (took ? 1 : 0);
            if (took)
            begin
                due_results.push_back(apply_job_cmd(job_cmds.pop_front()));
                n_sent <= sent_now;
            end
            calm = (sent_now >= CALM_LO && sent_now < CALM_HI);
            // Hold a flagged command back until every earlier result has been taken.
            drain_wait = job_cmds.size() != 0 && job_cmds[0].drain_first && n_done != sent_now;
            if (in_valid && !took)
                ;   // hold the stalled beat unchanged
            else if (job_cmds.size() != 0 && !drain_wait &&
                     (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                in_valid     <= 1'b1;
                cmd          <= job_cmds[0].op;
                job_id       <= job_cmds[0].id;
                job_priority <= job_cmds[0].prio;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check each result beat against the oldest owed result, then pick
    // the next stall value.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_done <= n_done + 1;
                if (due_results.size() == 0)
                begin
                    $error("result beat with nothing owed: status=%0d id=%0d priority=%0d",
                           status, out_id, out_priority);
                    err_cnt++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        err_cnt++;
                    end
                    if (out_id !== want.job.id)
                    begin
                        $error("out_id: expected %0d, got %0d", want.job.id, out_id);
                        err_cnt++;
                    end
                    if (out_priority !== want.job.prio)
                    begin
                        $error("out_priority: expected %0d, got %0d",
                               $signed(want.job.prio), out_priority);
                        err_cnt++;
                    end
                end
            end

            // Once, hold off for a long stretch so the output register fills and
            // the block has to stall its input.
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && n_done >= HOLD_AT)
            begin
                out_stall <= 1'b1;
                hold_left <= HOLD_CYCLES - 1;
                hold_done <= 1'b1;
            end
            else if (n_done >= CALM_LO && n_done < CALM_HI)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
